// ===== design/assert_macros.svh =====
// Assertion macros shared by the tokenizer modules.
// Depends on nothing; each macro takes a clock and a synchronous reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define ASSERT_SAME(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("assertion failed");

// The condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("assertion failed");

`endif

// ===== design/stok_pkg.sv =====
// Shared types and constants of the script tokenizer.
// Used by the front, queue, back and top modules; depends on nothing.
package stok_pkg;

   localparam int MAX_TOKEN_LEN = 1024;
   // Stored token length stays below MAX_TOKEN_LEN while a token is open.
   localparam int LEN_W = $clog2(MAX_TOKEN_LEN);
   localparam int LINE_W = 16;

   // One byte causes at most four result words.
   localparam int SLOTS = 4;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_NL    = 8'h0A;

   typedef enum logic [2:0] {
      PH_SKIP,
      PH_COMMENT,
      PH_QUOTED,
      PH_REGULAR,
      PH_HALT
   } phase_type;

   typedef enum logic [1:0] {
      KIND_BYTE,
      KIND_END,
      KIND_EOS,
      KIND_ERR
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [7:0]          token_byte;
      logic                quoted;
      logic                new_line;
      logic [LINE_W-1:0]   line_number;
   } result_type;

   typedef struct packed {
      logic [CNT_W-1:0]              count;
      result_type [SLOTS-1:0]        slot;
   } bundle_type;

   function automatic result_type make_result(kind_type k, logic [7:0] b, logic q,
                                              logic nl, logic [LINE_W-1:0] ln);
      result_type r;
      r.kind = k;
      r.token_byte = b;
      r.quoted = q;
      r.new_line = nl;
      r.line_number = ln;
      return r;
   endfunction

endpackage

// ===== design/script_tokenizer_top.sv =====
// Top level of the script tokenizer: lexer front end, bundle queue and
// result sequencer. Uses stok_pkg, stok_front, stok_queue and stok_back.
//
//   Channel   Handshake       Moves
//   req       push / full     one script byte per word
//   rsp       empty / pop     one result word (token byte, end, end of stream, error)
//
// A byte is taken every cycle while the queue has room; the front end
// classifies it and updates the lexer state in that cycle.
// A byte causes zero to four result words; the sequencer sends one word per
// cycle unless the result side stalls.
// The first word of a byte goes through a queue entry and the result register.
// Reset is synchronous and returns the lexer to skipping whitespace on line 1.
// The four-entry queue lets the byte side keep going while results stall.

module script_tokenizer_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  logic [7:0]   req_data_byte,
   input  logic         req_end_of_buffer,
   output logic         empty,
   input  logic         pop,
   output logic [1:0]   rsp_kind,
   output logic [7:0]   rsp_token_byte,
   output logic         rsp_quoted,
   output logic         rsp_new_line,
   output logic [15:0]  rsp_line_number,
   output logic         rsp_last
);

   logic                   accept;
   logic                   q_push;
   stok_pkg::bundle_type   q_in;
   logic                   q_full;
   logic                   q_pop;
   logic                   q_valid;
   stok_pkg::bundle_type   q_head;
   stok_pkg::result_type   result;

   assign accept = push && !q_full;
   assign full   = q_full;

   stok_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_data_byte),
      .end_of_buffer (req_end_of_buffer),
      .push          (q_push),
      .bundle        (q_in)
   );

   stok_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (q_push),
      .push_bundle (q_in),
      .full        (q_full),
      .pop         (q_pop),
      .valid       (q_valid),
      .head        (q_head)
   );

   stok_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head       (q_head),
      .head_pop   (q_pop),
      .out_pop    (pop),
      .out_empty  (empty),
      .out_result (result),
      .out_last   (rsp_last)
   );

   assign rsp_kind        = result.kind;
   assign rsp_token_byte  = result.token_byte;
   assign rsp_quoted      = result.quoted;
   assign rsp_new_line    = result.new_line;
   assign rsp_line_number = result.line_number;

endmodule

// ===== design/stok_front.sv =====
// Lexer front end: takes one script byte per accepted cycle, updates the lexer
// state and hands the words it causes to the queue as one bundle. Uses stok_pkg.
`include "assert_macros.svh"

module stok_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             data_byte,
   input  logic                   end_of_buffer,
   output logic                   push,
   output stok_pkg::bundle_type   bundle
);

   stok_pkg::phase_type               phase_ff, phase_in;
   logic [stok_pkg::LEN_W-1:0]        len_ff, len_in;
   logic [stok_pkg::LINE_W-1:0]       line_ff, line_in;
   logic                              saw_ff, saw_in;
   logic                              slash_ff, slash_in;

   logic [stok_pkg::CNT_W-1:0]        cnt;
   logic                              do_reg;
   logic                              tok_out;
   logic                              tok_q;
   logic                              is_ws;
   logic                              is_nl;

   assign is_ws = data_byte <= stok_pkg::CH_SPACE;
   assign is_nl = data_byte == stok_pkg::CH_NL;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= stok_pkg::PH_SKIP;
         len_ff   <= '0;
         line_ff  <= stok_pkg::LINE_W'(1);
         saw_ff   <= 1'b0;
         slash_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         line_ff  <= line_in;
         saw_ff   <= saw_in;
         slash_ff <= slash_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      line_in  = line_ff;
      saw_in   = saw_ff;
      slash_in = slash_ff;
      cnt      = '0;
      do_reg   = 1'b0;
      tok_out  = 1'b0;
      tok_q    = 1'b0;
      bundle   = '0;

      if (phase_ff == stok_pkg::PH_HALT) begin
         // Everything up to the end of the buffer is dropped.
      end else if (slash_ff) begin
         slash_in = 1'b0;
         if (data_byte == stok_pkg::CH_SLASH) begin
            phase_in = stok_pkg::PH_COMMENT;
            saw_in   = 1'b1;
         end else begin
            // The held slash opens a regular token; this byte continues it or ends it.
            phase_in = stok_pkg::PH_REGULAR;
            bundle.slot[cnt[stok_pkg::SLOT_W-1:0]] = stok_pkg::make_result(
               stok_pkg::KIND_BYTE, stok_pkg::CH_SLASH, 1'b0, saw_in, line_in);
            cnt    = cnt + 1'b1;
            len_in = stok_pkg::LEN_W'(1);
            do_reg = 1'b1;
         end
      end else begin
         case (phase_ff)
            stok_pkg::PH_SKIP: begin
               if (is_ws) begin
                  if (is_nl) begin
                     if (line_in != '1) line_in = line_in + 1'b1;
                     saw_in = 1'b1;
                  end
               end else if (data_byte == stok_pkg::CH_SEMI ||
                            data_byte == stok_pkg::CH_HASH) begin
                  phase_in = stok_pkg::PH_COMMENT;
                  saw_in   = 1'b1;
               end else if (data_byte == stok_pkg::CH_SLASH) begin
                  slash_in = 1'b1;
               end else if (data_byte == stok_pkg::CH_QUOTE) begin
                  phase_in = stok_pkg::PH_QUOTED;
                  len_in   = '0;
               end else begin
                  phase_in = stok_pkg::PH_REGULAR;
                  len_in   = '0;
                  do_reg   = 1'b1;
               end
            end
            stok_pkg::PH_COMMENT: begin
               if (is_nl) begin
                  if (line_in != '1) line_in = line_in + 1'b1;
                  saw_in   = 1'b1;
                  phase_in = stok_pkg::PH_SKIP;
               end
            end
            stok_pkg::PH_QUOTED: begin
               if (data_byte == stok_pkg::CH_QUOTE) begin
                  bundle.slot[cnt[stok_pkg::SLOT_W-1:0]] = stok_pkg::make_result(
                     stok_pkg::KIND_END, 8'd0, 1'b1, saw_in, line_in);
                  cnt      = cnt + 1'b1;
                  saw_in   = 1'b0;
                  len_in   = '0;
                  phase_in = stok_pkg::PH_SKIP;
               end else begin
                  tok_out = 1'b1;
                  tok_q   = 1'b1;
               end
            end
            stok_pkg::PH_REGULAR: begin
               do_reg = 1'b1;
            end
            default: begin
               phase_in = stok_pkg::PH_SKIP;
            end
         endcase
      end

      if (do_reg) begin
         if (is_ws || data_byte == stok_pkg::CH_SEMI) begin
            // The token end carries the old line; a newline is counted after it.
            bundle.slot[cnt[stok_pkg::SLOT_W-1:0]] = stok_pkg::make_result(
               stok_pkg::KIND_END, 8'd0, 1'b0, saw_in, line_in);
            cnt    = cnt + 1'b1;
            saw_in = 1'b0;
            len_in = '0;
            if (data_byte == stok_pkg::CH_SEMI) begin
               phase_in = stok_pkg::PH_COMMENT;
               saw_in   = 1'b1;
            end else begin
               phase_in = stok_pkg::PH_SKIP;
               if (is_nl) begin
                  if (line_in != '1) line_in = line_in + 1'b1;
                  saw_in = 1'b1;
               end
            end
         end else begin
            tok_out = 1'b1;
            tok_q   = 1'b0;
         end
      end

      if (tok_out) begin
         bundle.slot[cnt[stok_pkg::SLOT_W-1:0]] = stok_pkg::make_result(
            stok_pkg::KIND_BYTE, data_byte, tok_q, saw_in, line_in);
         cnt = cnt + 1'b1;
         if (len_in == stok_pkg::LEN_W'(stok_pkg::MAX_TOKEN_LEN - 1) && !end_of_buffer) begin
            bundle.slot[cnt[stok_pkg::SLOT_W-1:0]] = stok_pkg::make_result(
               stok_pkg::KIND_ERR, 8'd0, tok_q, saw_in, line_in);
            cnt      = cnt + 1'b1;
            phase_in = stok_pkg::PH_HALT;
         end
         len_in = len_in + 1'b1;
      end

      if (end_of_buffer) begin
         if (phase_in != stok_pkg::PH_HALT) begin
            if (slash_in) begin
               bundle.slot[cnt[stok_pkg::SLOT_W-1:0]] = stok_pkg::make_result(
                  stok_pkg::KIND_BYTE, stok_pkg::CH_SLASH, 1'b0, saw_in, line_in);
               cnt = cnt + 1'b1;
               bundle.slot[cnt[stok_pkg::SLOT_W-1:0]] = stok_pkg::make_result(
                  stok_pkg::KIND_END, 8'd0, 1'b0, saw_in, line_in);
               cnt = cnt + 1'b1;
            end else if (phase_in == stok_pkg::PH_REGULAR ||
                         phase_in == stok_pkg::PH_QUOTED) begin
               bundle.slot[cnt[stok_pkg::SLOT_W-1:0]] = stok_pkg::make_result(
                  stok_pkg::KIND_END, 8'd0, phase_in == stok_pkg::PH_QUOTED,
                  saw_in, line_in);
               cnt = cnt + 1'b1;
            end
         end
         bundle.slot[cnt[stok_pkg::SLOT_W-1:0]] = stok_pkg::make_result(
            stok_pkg::KIND_EOS, 8'd0, 1'b0, saw_in, line_in);
         cnt = cnt + 1'b1;
         phase_in = stok_pkg::PH_SKIP;
         len_in   = '0;
         line_in  = stok_pkg::LINE_W'(1);
         saw_in   = 1'b0;
         slash_in = 1'b0;
      end

      bundle.count = cnt;
   end

   assign push = accept && (cnt != '0);

   `ASSERT_SAME(a_halt_silent, clock, reset,
      accept && phase_ff == stok_pkg::PH_HALT && !end_of_buffer, !push)
   `ASSERT_NEXT(a_eob_resets, clock, reset,
      accept && end_of_buffer, phase_ff == stok_pkg::PH_SKIP && !slash_ff)

endmodule

// ===== design/stok_queue.sv =====
// Short queue of result bundles between the lexer front end and the
// result sequencer. Uses stok_pkg for the bundle type and depth.
`include "assert_macros.svh"

module stok_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  stok_pkg::bundle_type   push_bundle,
   output logic                   full,
   input  logic                   pop,
   output logic                   valid,
   output stok_pkg::bundle_type   head
);

   stok_pkg::bundle_type           entry_ff [stok_pkg::QUEUE_DEPTH];
   logic [stok_pkg::QPTR_W-1:0]    wr_ptr_ff;
   logic [stok_pkg::QPTR_W-1:0]    rd_ptr_ff;
   logic [stok_pkg::QCNT_W-1:0]    count_ff, count_in;

   assign full  = count_ff == stok_pkg::QCNT_W'(stok_pkg::QUEUE_DEPTH);
   assign valid = count_ff != '0;
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !(pop && valid)) count_in = count_ff + 1'b1;
      else if (!push && pop && valid) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop && valid) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   `ASSERT_SAME(a_no_push_full, clock, reset, push, !full)
   `ASSERT_SAME(a_count_range, clock, reset, 1'b1,
      count_ff <= stok_pkg::QCNT_W'(stok_pkg::QUEUE_DEPTH))

endmodule

// ===== design/stok_back.sv =====
// Result sequencer: walks the words of the head bundle, one a cycle while
// not stalled, into the result register. Uses stok_pkg for the bundle type.
`include "assert_macros.svh"

module stok_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  stok_pkg::bundle_type   head,
   output logic                   head_pop,
   input  logic                   out_pop,
   output logic                   out_empty,
   output stok_pkg::result_type   out_result,
   output logic                   out_last
);

   logic [stok_pkg::SLOT_W-1:0]    idx_ff, idx_in;
   logic                           valid_ff, valid_in;
   stok_pkg::result_type           result_ff, result_in;
   logic                           last_ff, last_in;
   logic                           load;
   logic                           is_last;

   // The result register refills in the same cycle that its word is taken.
   assign load    = head_valid && (!valid_ff || out_pop);
   assign is_last = stok_pkg::CNT_W'(idx_ff) == head.count - 1'b1;
   assign head_pop = load && is_last;

   always_comb begin
      idx_in    = idx_ff;
      valid_in  = valid_ff && !out_pop;
      result_in = result_ff;
      last_in   = last_ff;
      if (load) begin
         valid_in  = 1'b1;
         result_in = head.slot[idx_ff];
         last_in   = is_last;
         idx_in    = is_last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
      last_ff   <= last_in;
   end

   assign out_empty  = !valid_ff;
   assign out_result = result_ff;
   assign out_last   = last_ff;

   `ASSERT_SAME(a_idx_in_bundle, clock, reset, head_valid,
      stok_pkg::CNT_W'(idx_ff) < head.count)

endmodule
